FILE: design/xtt_pkg.sv
`timescale 1ns / 1ps

package xtt_pkg;

  localparam int XTT_TABLE_DEPTH = 64;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_REQUEST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESPONSE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MATCHED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TICK     = 3'd4;

  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD  = 1'd1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd60;
  localparam logic [7:0]  PERIOD_RESET  = 8'd10;

  typedef struct packed {
    logic take_item;
    logic clr_step;
    logic scan_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic needs_scan;
    logic out_busy;
  } stat_t;

endpackage

FILE: design/xtt_ctrl.sv
`timescale 1ns / 1ps

module xtt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  input  xtt_pkg::stat_t stat,
  output xtt_pkg::cmd_t  cmd
);
  import xtt_pkg::*;

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    SCAN,
    DRAIN,
    FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= CLEAR;
      s_ready <= 1'b0;
    end else begin
      case (state)
        CLEAR: begin
          if (stat.clr_last) begin
            state   <= IDLE;
            s_ready <= 1'b1;
          end
        end
        IDLE: begin
          if (s_valid && s_ready) begin
            s_ready <= 1'b0;
            state   <= stat.needs_scan ? SCAN : FINISH;
          end
        end
        SCAN: begin
          if (stat.scan_last) state <= DRAIN;
        end
        // last entry read comes back here
        DRAIN: begin
          state <= FINISH;
        end
        FINISH: begin
          if (!stat.out_busy) begin
            state   <= IDLE;
            s_ready <= 1'b1;
          end
        end
        default: begin
          state   <= CLEAR;
          s_ready <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.clr_step  = (state == CLEAR);
    cmd.take_item = (state == IDLE) && s_valid && s_ready;
    cmd.scan_step = (state == SCAN);
    cmd.load_out  = (state == FINISH) && !stat.out_busy;
  end

endmodule

FILE: design/xtt_datapath.sv
`timescale 1ns / 1ps

module xtt_datapath #(
  parameter int TABLE_DEPTH = xtt_pkg::XTT_TABLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [xtt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [xtt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [xtt_pkg::IN_DATA_W-1:0]      s_data,
  input  logic [xtt_pkg::KIND_W-1:0]         s_kind,
  output logic                               m_valid,
  input  logic                               m_ready,
  output logic [xtt_pkg::OUT_DATA_W-1:0]     m_data,
  output logic [xtt_pkg::STATUS_W-1:0]       m_status,
  input  xtt_pkg::cmd_t                      cmd,
  output xtt_pkg::stat_t                     stat
);
  import xtt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] addr;
    logic [15:0] portnum;
    logic [31:0] stamp;
    logic [31:0] serial;
  } entry_t;

  logic   valid_mem [TABLE_DEPTH];
  entry_t pay_mem   [TABLE_DEPTH];

  logic [15:0] timeout_seconds;
  logic [7:0]  sweep_period;
  logic [31:0] now_seconds;
  logic [31:0] next_serial;
  logic [7:0]  sweep_countdown;

  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] eval_idx;
  logic             eval_vld;
  logic             v_rd;
  entry_t           p_rd;

  logic [KIND_W-1:0] kind_q;
  logic [31:0]       xid_q;
  logic [31:0]       ip_q;
  logic [15:0]       port_q;
  logic              sweep_q;

  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             best_found;
  logic [IDX_W-1:0] best_idx;
  logic [31:0]      best_age;
  logic [31:0]      best_ip;
  logic [15:0]      best_port;
  logic [COUNT_W-1:0] expired;

  logic [31:0] age;
  logic        hit;
  logic        expire;
  logic        take_free;
  logic        ins_commit;
  logic        match_commit;

  logic             vwe;
  logic [IDX_W-1:0] vwaddr;
  logic             vwdata;

  logic [STATUS_W-1:0] res_status;
  logic [31:0]         res_ip;
  logic [15:0]         res_port;
  logic [COUNT_W-1:0]  res_count;

  assign age    = next_serial - p_rd.serial;
  assign hit    = eval_vld && (kind_q == KIND_RESPONSE) && v_rd && (p_rd.id == xid_q);
  assign expire = eval_vld && sweep_q && v_rd &&
                  ((now_seconds - p_rd.stamp) > {16'd0, timeout_seconds});
  assign take_free    = eval_vld && (kind_q == KIND_REQUEST) && !v_rd && !free_found;
  assign ins_commit   = cmd.load_out && (kind_q == KIND_REQUEST) && free_found;
  assign match_commit = cmd.load_out && (kind_q == KIND_RESPONSE) && best_found;

  always_comb begin
    stat.clr_last   = (clr_idx == LAST_IDX);
    stat.scan_last  = (scan_idx == LAST_IDX);
    stat.needs_scan = (s_kind inside {KIND_REQUEST, KIND_RESPONSE}) ||
                      ((s_kind == KIND_TICK) && (sweep_countdown == 8'd0));
    stat.out_busy   = m_valid && !m_ready;
  end

  // single write port of the valid store
  always_comb begin
    vwe    = 1'b0;
    vwaddr = clr_idx;
    vwdata = 1'b0;
    if (cmd.clr_step) begin
      vwe = 1'b1;
    end else if (expire) begin
      vwe    = 1'b1;
      vwaddr = eval_idx;
    end else if (ins_commit) begin
      vwe    = 1'b1;
      vwaddr = free_idx;
      vwdata = 1'b1;
    end else if (match_commit) begin
      vwe    = 1'b1;
      vwaddr = best_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) valid_mem[vwaddr] <= vwdata;
    if (cmd.scan_step) v_rd <= valid_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (ins_commit) begin
      pay_mem[free_idx] <= '{id: xid_q, addr: ip_q, portnum: port_q,
                             stamp: now_seconds, serial: next_serial};
    end
    if (cmd.scan_step) p_rd <= pay_mem[scan_idx];
  end

  always_comb begin
    res_status = ST_TICK;
    res_ip     = 32'd0;
    res_port   = 16'd0;
    res_count  = '0;
    case (kind_q)
      KIND_REQUEST: begin
        res_status = free_found ? ST_INSERTED : ST_FULL;
      end
      KIND_RESPONSE: begin
        if (best_found) begin
          res_status = ST_MATCHED;
          res_ip     = best_ip;
          res_port   = best_port;
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      KIND_TICK: begin
        res_count = expired;
      end
      default: begin
        res_status = ST_TICK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds <= TIMEOUT_RESET;
      sweep_period    <= PERIOD_RESET;
      now_seconds     <= 32'd0;
      next_serial     <= 32'd0;
      sweep_countdown <= 8'd0;
      clr_idx         <= '0;
      scan_idx        <= '0;
      eval_vld        <= 1'b0;
      sweep_q         <= 1'b0;
      free_found      <= 1'b0;
      best_found      <= 1'b0;
      expired         <= '0;
      m_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_TIMEOUT: timeout_seconds <= cfg_data;
          REG_PERIOD:  sweep_period    <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (cmd.clr_step) clr_idx <= (clr_idx == LAST_IDX) ? '0 : clr_idx + 1'b1;

      eval_vld <= cmd.scan_step;
      if (cmd.scan_step) scan_idx <= (scan_idx == LAST_IDX) ? '0 : scan_idx + 1'b1;

      if (cmd.take_item) begin
        scan_idx   <= '0;
        free_found <= 1'b0;
        best_found <= 1'b0;
        expired    <= '0;
        sweep_q    <= 1'b0;
        if (s_kind == KIND_TICK) begin
          now_seconds <= now_seconds + 32'd1;
          if (sweep_countdown == 8'd0) begin
            sweep_q         <= 1'b1;
            sweep_countdown <= (sweep_period == 8'd0) ? 8'd0 : sweep_period - 8'd1;
          end else begin
            sweep_countdown <= sweep_countdown - 8'd1;
          end
        end
      end

      if (take_free) free_found <= 1'b1;
      if (hit && (!best_found || (age > best_age))) best_found <= 1'b1;
      if (expire && (expired != {COUNT_W{1'b1}})) expired <= expired + 1'b1;

      if (ins_commit) next_serial <= next_serial + 32'd1;

      if (cmd.load_out) m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.scan_step) eval_idx <= scan_idx;
    if (cmd.take_item) begin
      kind_q <= s_kind;
      xid_q  <= s_data[31:0];
      ip_q   <= s_data[63:32];
      port_q <= s_data[79:64];
    end
    if (take_free) free_idx <= eval_idx;
    // oldest match wins: largest distance back from the serial counter
    if (hit && (!best_found || (age > best_age))) begin
      best_idx  <= eval_idx;
      best_age  <= age;
      best_ip   <= p_rd.addr;
      best_port <= p_rd.portnum;
    end
    if (cmd.load_out) begin
      m_status <= res_status;
      m_data   <= {1'b0, res_count, res_port, res_ip};
    end
  end

endmodule

FILE: design/xid_transaction_table_with_aging.sv
`timescale 1ns / 1ps

// channel   dir  handshake                      tdata / tuser
// s_axis    in   s_axis_tvalid / s_axis_tready  xid, client_ip, client_port / kind
// m_axis    out  m_axis_tvalid / m_axis_tready  reply_ip, reply_port, expired_count / status
// cfg       in   cfg_we (no wait)               cfg_addr 0 timeout_seconds, 1 sweep_period
//
// requests, responses and sweeping ticks walk the whole table through one memory
// read port, one entry a cycle
// ticks without a sweep and unused kinds skip the scan and go straight to the result
// after rst a clearing pass over every entry resets the valid store, tready low
// one item is in flight at a time; a stalled result holds the block in its last step
module xid_transaction_table_with_aging #(
  parameter int TABLE_DEPTH = xtt_pkg::XTT_TABLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [xtt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [xtt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] xid, [63:32] client_ip, [79:64] client_port
  input  logic [xtt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [1:0] kind
  input  logic [xtt_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] reply_ip, [47:32] reply_port, [54:48] expired_count, [55] zero
  output logic [xtt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [2:0] status
  output logic [xtt_pkg::STATUS_W-1:0]       m_axis_tuser
);
  import xtt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  xtt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  xtt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_data   (s_axis_tdata),
    .s_kind   (s_axis_tuser),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_data   (m_axis_tdata),
    .m_status (m_axis_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
